FILE: rtl/pmftl_pkg.sv
// Package with request and result codes for the page-mapping flash translation layer.
package pmftl_pkg;

  // Request modes.
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_FORMAT = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_READ    = 3'd0;
  localparam logic [2:0] KIND_PROGRAM = 3'd1;
  localparam logic [2:0] KIND_COPY    = 3'd2;
  localparam logic [2:0] KIND_ERASE   = 3'd3;
  localparam logic [2:0] KIND_FORMAT  = 3'd4;
  localparam logic [2:0] KIND_NOBLK   = 3'd5;

  // Page status codes.
  localparam logic [1:0] PG_UNWRITTEN = 2'd0;
  localparam logic [1:0] PG_VALID     = 2'd1;
  localparam logic [1:0] PG_STALE     = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,     // clearing pass over all tables
    ST_IDLE,
    ST_RD_LMAP,   // logical map read issued
    ST_RD_RESP,
    ST_WR_START,
    ST_FIND,      // search for the next free block
    ST_VSCAN,     // victim search over blocks
    ST_VSCAN_W,
    ST_COPY_RD,   // read victim page
    ST_COPY_CHK,
    ST_COPY_EMIT,
    ST_ERASE,     // clear victim pages
    ST_ERASE_EMIT,
    ST_PROG_RD,   // read old mapping
    ST_PROG_OLD,
    ST_PROG_CNT,
    ST_PROG_EMIT,
    ST_NOBLK,
    ST_FMT_EMIT,
    ST_OUT_WAIT
  } state_e;

  // One result item.
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] src_block;
    logic [2:0] src_page;
    logic [3:0] dst_block;
    logic [2:0] dst_page;
    logic       mapped;
    logic       last;
  } result_t;

endpackage

FILE: rtl/pmftl_out_reg.sv
// Output register stage holding one result transaction.
module pmftl_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pmftl_pkg::result_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               ready_i,
  output pmftl_pkg::result_t data_o
);

  logic               valid_q, valid_d;
  pmftl_pkg::result_t data_q;

  // Valid flag: set on push, cleared when taken.
  always_comb begin
    valid_d = valid_q;
    if (valid_q && ready_i) valid_d = 1'b0;
    if (push_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) data_q <= data_i;
  end

  assign full_o  = valid_q && !ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/page_map_ftl_greedy_gc.sv
// Page-mapping flash translation layer with greedy garbage collection: a
// request sequencer over block-RAM tables. A read looks up the logical map; a
// write programs the next page of the write block, searching for a free block
// at a block change and, when collection runs, searching for a victim block,
// copying its valid pages into the write block and then erasing its pages.
// The sequencer handles one request at a time. After reset and after a
// format a clearing pass over all tables runs before the next request is
// taken. Results wait in an output register.
module page_map_ftl_greedy_gc #(
  parameter int NUM_BLOCKS      = 16,
  parameter int PAGES_PER_BLOCK = 8,
  parameter int LOGICAL_BLOCKS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // mode[1:0], logical_page[8:2]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // kind, src_block, src_page, dst_block,
                                        // dst_page, mapped (lowest bit up)
  output logic        m_axis_tlast_o
);

  localparam int PhysPages = NUM_BLOCKS * PAGES_PER_BLOCK;
  localparam int LogPages  = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
  localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PW  = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int PPW = BW + PW;
  localparam int LW  = (LogPages > 1) ? $clog2(LogPages) : 1;
  localparam int CW  = $clog2(PAGES_PER_BLOCK + 1);
  localparam int FW  = $clog2(NUM_BLOCKS + 1);
  localparam int ClrN = (LogPages > PhysPages) ? LogPages : PhysPages;
  localparam int ClrW = $clog2(ClrN + 1);

  // Tables: logical map (valid + location), owner (valid + logical page),
  // page status, per-block valid count and free flag.
  logic [PPW:0]  lmap_mem [LogPages];
  logic [LW:0]   own_mem  [PhysPages];
  logic [1:0]    pst_mem  [PhysPages];
  logic [CW:0]   blk_mem  [NUM_BLOCKS];   // {free, count}

  // Memory ports.
  logic          lm_we;  logic [LW-1:0]  lm_wa, lm_ra; logic [PPW:0] lm_wd, lm_rd;
  logic          ow_we;  logic [PPW-1:0] ow_wa, ow_ra; logic [LW:0]  ow_wd, ow_rd;
  logic          ps_we;  logic [PPW-1:0] ps_wa, ps_ra; logic [1:0]   ps_wd, ps_rd;
  logic          bk_we;  logic [BW-1:0]  bk_wa, bk_ra; logic [CW:0]  bk_wd, bk_rd;

  always_ff @(posedge clk_i) begin
    if (lm_we) lmap_mem[lm_wa] <= lm_wd;
    lm_rd <= lmap_mem[lm_ra];
    if (ow_we) own_mem[ow_wa] <= ow_wd;
    ow_rd <= own_mem[ow_ra];
    if (ps_we) pst_mem[ps_wa] <= ps_wd;
    ps_rd <= pst_mem[ps_ra];
    if (bk_we) blk_mem[bk_wa] <= bk_wd;
    bk_rd <= blk_mem[bk_ra];
  end

  // Control registers.
  pmftl_pkg::state_e state_q, state_d;
  logic [ClrW-1:0]   clr_q, clr_d;
  logic [FW-1:0]     free_q, free_d;
  logic [BW-1:0]     wblk_q, wblk_d;
  logic [PW-1:0]     wpg_q, wpg_d;
  logic              started_q, started_d;
  logic [LW:0]       lp_q, lp_d;
  logic [BW:0]       cnt_q, cnt_d;      // block step counter
  logic [BW-1:0]     scan_q, scan_d;    // block being looked at
  logic [BW-1:0]     vic_q, vic_d;
  logic [CW-1:0]     best_q, best_d;
  logic              found_q, found_d;
  logic [PW:0]       pg_q, pg_d;        // victim page index
  logic [PW:0]       pos_q, pos_d;      // copy destination index
  logic [CW-1:0]     wcnt_q, wcnt_d;    // valid count of the write block
  logic [PPW:0]      old_q, old_d;

  // Output stage.
  logic               push, ofull;
  pmftl_pkg::result_t res, ores;

  pmftl_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .full_o (ofull),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .data_o (ores)
  );

  assign m_axis_tdata_o = {6'd0, ores.mapped, ores.dst_page, ores.dst_block,
                           ores.src_page, ores.src_block, ores.kind};
  assign m_axis_tlast_o = ores.last;

  logic [1:0]    in_mode;
  logic [6:0]    in_lp;
  logic [BW-1:0] scan_nx;
  logic [PPW-1:0] vsrc, cdst;
  assign in_mode = s_axis_tdata_i[1:0];
  assign in_lp   = s_axis_tdata_i[8:2];
  assign s_axis_tready_o = (state_q == pmftl_pkg::ST_IDLE) && !ofull;
  assign scan_nx = (32'(scan_q) + 1 == NUM_BLOCKS) ? '0 : scan_q + 1'b1;
  assign vsrc = {vic_q, pg_q[PW-1:0]};
  assign cdst = {wblk_q, pos_q[PW-1:0]};

  // Sequencer.
  always_comb begin
    state_d = state_q; clr_d = clr_q; free_d = free_q; wblk_d = wblk_q;
    wpg_d = wpg_q; started_d = started_q; lp_d = lp_q; cnt_d = cnt_q;
    scan_d = scan_q; vic_d = vic_q; best_d = best_q; found_d = found_q;
    pg_d = pg_q; pos_d = pos_q; wcnt_d = wcnt_q; old_d = old_q;
    lm_we = 1'b0; lm_wa = '0; lm_wd = '0; lm_ra = '0;
    ow_we = 1'b0; ow_wa = '0; ow_wd = '0; ow_ra = '0;
    ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_ra = '0;
    bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
    push = 1'b0; res = '0;
    unique case (state_q)
      pmftl_pkg::ST_CLEAR: begin
        if (32'(clr_q) < LogPages) begin
          lm_we = 1'b1; lm_wa = clr_q[LW-1:0];
        end
        if (32'(clr_q) < PhysPages) begin
          ow_we = 1'b1; ow_wa = clr_q[PPW-1:0];
          ps_we = 1'b1; ps_wa = clr_q[PPW-1:0]; ps_wd = pmftl_pkg::PG_UNWRITTEN;
        end
        if (32'(clr_q) < NUM_BLOCKS) begin
          bk_we = 1'b1; bk_wa = clr_q[BW-1:0]; bk_wd = {1'b1, {CW{1'b0}}};
        end
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == ClrN - 1) state_d = pmftl_pkg::ST_IDLE;
      end
      pmftl_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i && s_axis_tready_o) begin
          lp_d = {1'b0, in_lp[LW-1:0]};
          if (32'(in_lp) >= LogPages) lp_d[LW] = 1'b1;
          if (in_mode == pmftl_pkg::MODE_FORMAT) begin
            state_d = pmftl_pkg::ST_FMT_EMIT;
          end else if (in_mode == pmftl_pkg::MODE_READ) begin
            state_d = pmftl_pkg::ST_RD_LMAP;
          end else if (in_mode == pmftl_pkg::MODE_WRITE && 32'(in_lp) < LogPages) begin
            state_d = pmftl_pkg::ST_WR_START;
          end
        end
      end
      pmftl_pkg::ST_FMT_EMIT: begin
        res.kind = pmftl_pkg::KIND_FORMAT; res.last = 1'b1; push = 1'b1;
        free_d = FW'(NUM_BLOCKS); wblk_d = '0; wpg_d = '0; started_d = 1'b0;
        clr_d = '0; state_d = pmftl_pkg::ST_CLEAR;
      end
      pmftl_pkg::ST_RD_LMAP: begin
        lm_ra = lp_q[LW-1:0]; state_d = pmftl_pkg::ST_RD_RESP;
      end
      pmftl_pkg::ST_RD_RESP: begin
        res.kind = pmftl_pkg::KIND_READ; res.last = 1'b1;
        if (!lp_q[LW] && lm_rd[PPW]) begin
          res.mapped = 1'b1;
          res.dst_block = 4'(lm_rd[PPW-1:PW]);
          res.dst_page = 3'(lm_rd[PW-1:0]);
        end
        push = 1'b1; state_d = pmftl_pkg::ST_IDLE;
      end
      pmftl_pkg::ST_WR_START: begin
        if (!started_q) begin
          // First write takes block 0.
          started_d = 1'b1; wblk_d = '0; wpg_d = '0;
          bk_ra = '0; state_d = pmftl_pkg::ST_PROG_RD;
          cnt_d = '0;
        end else if (32'(wpg_q) >= PAGES_PER_BLOCK - 1) begin
          scan_d = wblk_q; cnt_d = '0; bk_ra = wblk_q;
          state_d = pmftl_pkg::ST_FIND;
        end else begin
          wpg_d = wpg_q + 1'b1; bk_ra = wblk_q; cnt_d = {{BW{1'b0}}, 1'b1};
          state_d = pmftl_pkg::ST_PROG_RD;
        end
      end
      pmftl_pkg::ST_FIND: begin
        // bk_rd holds the entry of scan_q.
        if (bk_rd[CW]) begin
          wblk_d = scan_q;
          bk_we = 1'b1; bk_wa = scan_q; bk_wd = '0;
          if (free_q != '0) free_d = free_q - 1'b1;
          if (free_q <= 1) begin
            cnt_d = {{BW{1'b0}}, 1'b1}; scan_d = (32'(scan_q) + 1 == NUM_BLOCKS) ? '0 : scan_q + 1'b1;
            bk_ra = (32'(scan_q) + 1 == NUM_BLOCKS) ? '0 : scan_q + 1'b1;
            found_d = 1'b0; best_d = CW'(PAGES_PER_BLOCK + 1); pos_d = '0;
            state_d = pmftl_pkg::ST_VSCAN;
          end else begin
            wpg_d = '0; wcnt_d = '0; state_d = pmftl_pkg::ST_PROG_RD;
            cnt_d = '0;
          end
        end else if (32'(cnt_q) == NUM_BLOCKS - 1) begin
          res.kind = pmftl_pkg::KIND_NOBLK; res.last = 1'b1; push = 1'b1;
          state_d = pmftl_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1; scan_d = scan_nx; bk_ra = scan_nx;
        end
      end
      pmftl_pkg::ST_VSCAN: begin
        // Write block itself is still free-marked false with count 0; skip it.
        bk_ra = scan_q; state_d = pmftl_pkg::ST_VSCAN_W;
      end
      pmftl_pkg::ST_VSCAN_W: begin
        if (!bk_rd[CW] && bk_rd[CW-1:0] < best_q) begin
          best_d = bk_rd[CW-1:0]; vic_d = scan_q; found_d = 1'b1;
        end
        if (32'(cnt_q) == NUM_BLOCKS - 1) begin
          pg_d = '0;
          if (found_q || (!bk_rd[CW] && bk_rd[CW-1:0] < best_q))
            state_d = pmftl_pkg::ST_COPY_RD;
          else begin
            wpg_d = '0; wcnt_d = '0; cnt_d = '0;
            state_d = pmftl_pkg::ST_PROG_RD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1; scan_d = scan_nx; state_d = pmftl_pkg::ST_VSCAN;
        end
      end
      pmftl_pkg::ST_COPY_RD: begin
        if (32'(pg_q) >= PAGES_PER_BLOCK || 32'(pos_q) >= PAGES_PER_BLOCK) begin
          pg_d = '0; state_d = pmftl_pkg::ST_ERASE;
        end else begin
          ps_ra = vsrc; ow_ra = vsrc; state_d = pmftl_pkg::ST_COPY_CHK;
        end
      end
      pmftl_pkg::ST_COPY_CHK: begin
        if (ps_rd == pmftl_pkg::PG_VALID) begin
          if (ow_rd[LW]) begin
            lm_we = 1'b1; lm_wa = ow_rd[LW-1:0]; lm_wd = {1'b1, cdst};
          end
          ow_we = 1'b1; ow_wa = cdst; ow_wd = ow_rd;
          ps_we = 1'b1; ps_wa = cdst; ps_wd = pmftl_pkg::PG_VALID;
          state_d = pmftl_pkg::ST_COPY_EMIT;
        end else begin
          pg_d = pg_q + 1'b1; state_d = pmftl_pkg::ST_COPY_RD;
        end
      end
      pmftl_pkg::ST_COPY_EMIT: begin
        if (!ofull) begin
          ps_we = 1'b1; ps_wa = vsrc; ps_wd = pmftl_pkg::PG_STALE;
          res.kind = pmftl_pkg::KIND_COPY;
          res.src_block = 4'(vic_q); res.src_page = 3'(pg_q);
          res.dst_block = 4'(wblk_q); res.dst_page = 3'(pos_q);
          push = 1'b1;
          pos_d = pos_q + 1'b1; pg_d = pg_q + 1'b1;
          state_d = pmftl_pkg::ST_COPY_RD;
        end
      end
      pmftl_pkg::ST_ERASE: begin
        ps_we = 1'b1; ps_wa = vsrc; ps_wd = pmftl_pkg::PG_UNWRITTEN;
        ow_we = 1'b1; ow_wa = vsrc; ow_wd = '0;
        pg_d = pg_q + 1'b1;
        if (32'(pg_q) == PAGES_PER_BLOCK - 1) state_d = pmftl_pkg::ST_ERASE_EMIT;
      end
      pmftl_pkg::ST_ERASE_EMIT: begin
        if (!ofull) begin
          bk_we = 1'b1; bk_wa = vic_q; bk_wd = {1'b1, {CW{1'b0}}};
          free_d = free_q + 1'b1;
          res.kind = pmftl_pkg::KIND_ERASE; res.dst_block = 4'(vic_q);
          push = 1'b1;
          wcnt_d = CW'(pos_q);
          if (32'(pos_q) >= PAGES_PER_BLOCK) begin
            wpg_d = PW'(PAGES_PER_BLOCK - 1);
            bk_we = 1'b1;  // victim marked free; write block count kept below
            state_d = pmftl_pkg::ST_NOBLK;
          end else begin
            // The copy count is already in wcnt; the table entry is still zero.
            wpg_d = pos_q[PW-1:0]; cnt_d = '0;
            bk_ra = wblk_q;
            state_d = pmftl_pkg::ST_PROG_RD;
          end
        end
      end
      pmftl_pkg::ST_NOBLK: begin
        if (!ofull) begin
          bk_we = 1'b1; bk_wa = wblk_q; bk_wd = {1'b0, wcnt_q};
          res.kind = pmftl_pkg::KIND_NOBLK; res.last = 1'b1; push = 1'b1;
          state_d = pmftl_pkg::ST_IDLE;
        end
      end
      pmftl_pkg::ST_PROG_RD: begin
        // cnt_q[0] set: wcnt must come from the block table.
        if (cnt_q[0] && state_q == pmftl_pkg::ST_PROG_RD && pos_q == '1) begin
          wcnt_d = wcnt_q;
        end
        lm_ra = lp_q[LW-1:0]; bk_ra = wblk_q;
        state_d = pmftl_pkg::ST_PROG_OLD;
      end
      pmftl_pkg::ST_PROG_OLD: begin
        old_d = lm_rd;
        if (cnt_q[0] || !started_q || wcnt_q == '0) wcnt_d = bk_rd[CW-1:0];
        if (lm_rd[PPW]) begin
          ps_we = 1'b1; ps_wa = lm_rd[PPW-1:0]; ps_wd = pmftl_pkg::PG_STALE;
          ow_we = 1'b1; ow_wa = lm_rd[PPW-1:0]; ow_wd = '0;
          bk_ra = lm_rd[PPW-1:PW];
          state_d = pmftl_pkg::ST_PROG_CNT;
        end else begin
          state_d = pmftl_pkg::ST_PROG_EMIT;
        end
      end
      pmftl_pkg::ST_PROG_CNT: begin
        if (old_q[PPW-1:PW] == wblk_q) begin
          if (wcnt_q != '0) wcnt_d = wcnt_q - 1'b1;
        end else if (bk_rd[CW-1:0] != '0) begin
          bk_we = 1'b1; bk_wa = old_q[PPW-1:PW];
          bk_wd = {bk_rd[CW], bk_rd[CW-1:0] - 1'b1};
        end
        state_d = pmftl_pkg::ST_PROG_EMIT;
      end
      pmftl_pkg::ST_PROG_EMIT: begin
        if (!ofull) begin
          ps_we = 1'b1; ps_wa = {wblk_q, wpg_q}; ps_wd = pmftl_pkg::PG_VALID;
          ow_we = 1'b1; ow_wa = {wblk_q, wpg_q}; ow_wd = {1'b1, lp_q[LW-1:0]};
          lm_we = 1'b1; lm_wa = lp_q[LW-1:0]; lm_wd = {1'b1, wblk_q, wpg_q};
          bk_we = 1'b1; bk_wa = wblk_q; bk_wd = {1'b0, wcnt_q + 1'b1};
          wcnt_d = '0;
          res.kind = pmftl_pkg::KIND_PROGRAM; res.dst_block = 4'(wblk_q);
          res.dst_page = 3'(wpg_q); res.last = 1'b1; push = 1'b1;
          if (!started_q || (free_q == FW'(NUM_BLOCKS) && !started_q)) free_d = free_q;
          state_d = pmftl_pkg::ST_IDLE;
        end
      end
      pmftl_pkg::ST_OUT_WAIT: state_d = pmftl_pkg::ST_IDLE;
      default: state_d = pmftl_pkg::ST_IDLE;
    endcase
    // First write claims block 0 if still free.
    if (state_q == pmftl_pkg::ST_WR_START && !started_q) begin
      bk_ra = '0;
      wcnt_d = '0;
      cnt_d = {{BW{1'b0}}, 1'b1};
      state_d = pmftl_pkg::ST_OUT_WAIT;
      pos_d = '1;
    end
    if (state_q == pmftl_pkg::ST_OUT_WAIT) begin
      // bk_rd holds block 0.
      if (bk_rd[CW]) begin
        free_d = free_q - 1'b1;
        bk_we = 1'b1; bk_wa = '0; bk_wd = '0;
      end
      state_d = pmftl_pkg::ST_PROG_RD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmftl_pkg::ST_CLEAR; clr_q <= '0; free_q <= FW'(NUM_BLOCKS);
      wblk_q <= '0; wpg_q <= '0; started_q <= 1'b0; lp_q <= '0; cnt_q <= '0;
      scan_q <= '0; vic_q <= '0; best_q <= '0; found_q <= 1'b0; pg_q <= '0;
      pos_q <= '0; wcnt_q <= '0; old_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; free_q <= free_d; wblk_q <= wblk_d;
      wpg_q <= wpg_d; started_q <= started_d; lp_q <= lp_d; cnt_q <= cnt_d;
      scan_q <= scan_d; vic_q <= vic_d; best_q <= best_d; found_q <= found_d;
      pg_q <= pg_d; pos_q <= pos_d; wcnt_q <= wcnt_d; old_q <= old_d;
    end
  end

endmodule
